// ===== rtl/core/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg
// Shared types and constants of the unicycle pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

    localparam int VEL_W   = 16;
    localparam int SPD_W   = 17;              // fwd + side, exact
    localparam int ANG_W   = 32;              // binary angle
    localparam int CS_W    = 34;              // CORDIC x/y, Q1.30 plus guard
    localparam int Z_W     = 33;
    localparam int ITER_W  = 5;
    localparam int CORDIC_STEPS = 30;
    localparam int OUT_W   = 32;

    localparam logic [31:0] HEAD_STEP_C = 32'd2734261102;   // round(8/pi * 2^30)
    localparam logic [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORD0,
        ST_HMUL,
        ST_CORD1,
        ST_AMULX,
        ST_ADIVX,
        ST_AMULY,
        ST_ADIVY,
        ST_SMULX,
        ST_SMULY,
        ST_UPD
    } upi_state_t;

    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/upi_cordic.sv =====
// ----------------------------------------------------------------------------
// upi_cordic
// Iterative rotation-mode CORDIC: binary angle in, cos and sin in Q1.30 out.
// ----------------------------------------------------------------------------
module upi_cordic (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [upi_pkg::ANG_W-1:0]      angle,
    output logic                           done,
    output logic signed [upi_pkg::CS_W-1:0] cos_out,
    output logic signed [upi_pkg::CS_W-1:0] sin_out
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [upi_pkg::ITER_W-1:0]       iter_reg;
    logic [1:0]                       quad_reg;
    logic signed [upi_pkg::CS_W-1:0]  x_reg, y_reg;
    logic signed [upi_pkg::Z_W-1:0]   z_reg;

    logic [31:0]                      qsum;
    logic [1:0]                       quad;
    logic [31:0]                      resid;
    logic signed [upi_pkg::CS_W-1:0]  x_sh, y_sh, x_next, y_next;
    logic signed [upi_pkg::Z_W-1:0]   z_next, atan_s;

    // nearest quarter turn, residual within +-1/8 turn
    assign qsum  = angle + 32'h2000_0000;
    assign quad  = qsum[31:30];
    assign resid = angle - {quad, 30'd0};

    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign atan_s = signed'({1'b0, upi_pkg::atan_entry(iter_reg)});

    always_comb begin
        if (!z_reg[upi_pkg::Z_W-1]) begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_s;
        end else begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && iter_reg == upi_pkg::ITER_W'(upi_pkg::CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            iter_reg <= '0;
            quad_reg <= quad;
            x_reg    <= upi_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= signed'({resid[31], resid});
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    always_comb begin
        case (quad_reg)
            2'd0: begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1: begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2: begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default: begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/unicycle_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// Dead-reckoning pose integrator, velocity motion model, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per odometry sample (velocities, yaw rate, dt).
//   m_ channel: one beat per sample with the updated pose (x, y, heading).
//   One sample is processed at a time. s_tready is high only while the
//   sequencer is idle; a finished pose sits in the output register, so the
//   next sample is taken while that pose still waits for m_tready.
//   Steps per sample, accept to result valid:
//     zero yaw rate: prep, CORDIC, two serial multiplies, update
//     otherwise:     prep, CORDIC, multiply, CORDIC, 2 * (multiply + divide), update
//   The sequencer returns to idle on the clock edge that registers the
//   result. The arithmetic uses a bit-serial shift-add multiplier and a
//   restoring divider, with the 30-step CORDIC run once or twice.
//   Reset clears the position and heading to zero and empties the output
//   register. When m_tready is low the sequencer waits in its final step
//   until the held result is taken; no sample is lost.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator #(
    parameter int POSE_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // vel_fwd, vel_side, yaw_rate, step_time
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata    // pose_x, pose_y, pose_heading
);

    localparam int D_W     = 40;
    localparam int SUM_W   = ((POSE_WIDTH > D_W) ? POSE_WIDTH : D_W) + 1;
    localparam int ACC_W   = 64;
    localparam int DIV_W   = 49;
    localparam int DEN_W   = 30;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] MUL_END = CNT_W'(32);
    localparam logic [CNT_W-1:0] DIV_END = CNT_W'(DIV_W);

    upi_pkg::upi_state_t state_reg, state_next;

    logic signed [upi_pkg::SPD_W-1:0] v_reg;
    logic signed [15:0]               w_reg;
    logic [15:0]                      dt_reg;
    logic signed [32:0]               p_reg;
    logic signed [31:0]               prod_reg;
    logic signed [upi_pkg::CS_W-1:0]  c0_reg, s0_reg;
    logic [31:0]                      th1_reg;
    logic [ACC_W-1:0]                 acc_reg, mcand_reg;
    logic [31:0]                      mplier_reg;
    logic                             neg_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [30:0]                      rem_reg;
    logic [DIV_W-1:0]                 dq_reg;
    logic [DEN_W-1:0]                 den_reg;
    logic signed [D_W-1:0]            dx_reg, dy_reg;

    logic signed [POSE_WIDTH-1:0]     pos_x_reg, pos_y_reg;
    logic [31:0]                      heading_reg;
    logic                             m_tvalid_reg;
    logic [95:0]                      m_tdata_reg;

    // control
    logic                             cord_start, cord_done;
    logic [31:0]                      cord_angle;
    logic signed [upi_pkg::CS_W-1:0]  cord_cos, cord_sin;
    logic                             out_free;

    // datapath helpers
    logic [ACC_W-1:0]                 acc_step;
    logic [ACC_W-1:0]                 msum, rsum;
    logic [31:0]                      hstep, th1_comb;
    logic signed [D_W-1:0]            straight_d, div_d;
    logic [31:0]                      mag_p, mag_prod, mag_cos, mag_s0;
    logic [15:0]                      mag_w;
    logic [31:0]                      mag_v;
    logic signed [upi_pkg::CS_W:0]    diff_s, diff_c;
    logic [31:0]                      mag_ds, mag_dc;
    logic [31:0]                      trial;
    logic                             qbit;
    logic [DIV_W-1:0]                 div_init;
    logic signed [SUM_W-1:0]          sum_x, sum_y;
    logic signed [POSE_WIDTH-1:0]     sat_x, sat_y;
    logic signed [SUM_W-1:0]          ext_x, ext_y;
    logic [31:0]                      heading_new;

    upi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .angle   (cord_angle),
        .done    (cord_done),
        .cos_out (cord_cos),
        .sin_out (cord_sin)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            upi_pkg::ST_IDLE:  if (s_tvalid) state_next = upi_pkg::ST_PREP;
            upi_pkg::ST_PREP:  state_next = upi_pkg::ST_CORD0;
            upi_pkg::ST_CORD0: begin
                if (cord_done) begin
                    state_next = (w_reg == '0) ? upi_pkg::ST_SMULX : upi_pkg::ST_HMUL;
                end
            end
            upi_pkg::ST_HMUL:  if (cnt_reg == MUL_END) state_next = upi_pkg::ST_CORD1;
            upi_pkg::ST_CORD1: if (cord_done) state_next = upi_pkg::ST_AMULX;
            upi_pkg::ST_AMULX: if (cnt_reg == MUL_END) state_next = upi_pkg::ST_ADIVX;
            upi_pkg::ST_ADIVX: if (cnt_reg == DIV_END) state_next = upi_pkg::ST_AMULY;
            upi_pkg::ST_AMULY: if (cnt_reg == MUL_END) state_next = upi_pkg::ST_ADIVY;
            upi_pkg::ST_ADIVY: if (cnt_reg == DIV_END) state_next = upi_pkg::ST_UPD;
            upi_pkg::ST_SMULX: if (cnt_reg == MUL_END) state_next = upi_pkg::ST_SMULY;
            upi_pkg::ST_SMULY: if (cnt_reg == MUL_END) state_next = upi_pkg::ST_UPD;
            upi_pkg::ST_UPD:   if (out_free) state_next = upi_pkg::ST_IDLE;
            default:           state_next = upi_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        s_tready   = 1'b0;
        cord_start = 1'b0;
        cord_angle = heading_reg;
        case (state_reg)
            upi_pkg::ST_IDLE: s_tready = 1'b1;
            upi_pkg::ST_PREP: cord_start = 1'b1;
            upi_pkg::ST_HMUL: begin
                cord_start = (cnt_reg == MUL_END);
                cord_angle = th1_comb;
            end
            default: begin
                cord_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= upi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- arithmetic helpers ----------------
    assign acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // heading step: (|w*dt| * C + 2^29) >> 30, sign restored, mod 2^32
    assign msum     = acc_reg + (ACC_W'(1) << 29);
    assign hstep    = neg_reg ? -msum[61:30] : msum[61:30];
    assign th1_comb = heading_reg + hstep;

    // straight step: (|p*c| + 2^41) >> 42
    assign rsum       = acc_reg + (ACC_W'(1) << 41);
    assign straight_d = neg_reg ? -signed'(D_W'(rsum[63:42])) : signed'(D_W'(rsum[63:42]));
    assign div_d      = neg_reg ? -signed'(D_W'(dq_reg[D_W-2:0])) : signed'(D_W'(dq_reg[D_W-2:0]));

    assign mag_p    = p_reg[32] ? 32'(-p_reg) : p_reg[31:0];
    assign mag_prod = prod_reg[31] ? -prod_reg : prod_reg;
    assign mag_cos  = cord_cos[upi_pkg::CS_W-1] ? 32'(-cord_cos) : cord_cos[31:0];
    assign mag_s0   = s0_reg[upi_pkg::CS_W-1] ? 32'(-s0_reg) : s0_reg[31:0];
    assign mag_w    = w_reg[15] ? -w_reg : w_reg;
    assign mag_v    = 32'(v_reg[upi_pkg::SPD_W-1] ? -v_reg : v_reg);

    assign diff_s = {cord_sin[upi_pkg::CS_W-1], cord_sin} - {s0_reg[upi_pkg::CS_W-1], s0_reg};
    assign diff_c = {c0_reg[upi_pkg::CS_W-1], c0_reg} - {cord_cos[upi_pkg::CS_W-1], cord_cos};
    assign mag_ds = diff_s[upi_pkg::CS_W] ? 32'(-diff_s) : diff_s[31:0];
    assign mag_dc = diff_c[upi_pkg::CS_W] ? 32'(-diff_c) : diff_c[31:0];

    // restoring divider, one quotient bit per beat of the counter
    assign trial    = {rem_reg, dq_reg[DIV_W-1]};
    assign qbit     = (trial >= 32'(den_reg));
    assign div_init = acc_reg[DIV_W-1:0] + (DIV_W'(mag_w) << 13);

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            upi_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    v_reg  <= upi_pkg::SPD_W'(signed'(s_tdata[15:0]))
                            + upi_pkg::SPD_W'(signed'(s_tdata[31:16]));
                    w_reg  <= signed'(s_tdata[47:32]);
                    dt_reg <= s_tdata[63:48];
                end
            end
            upi_pkg::ST_PREP: begin
                p_reg    <= 33'(v_reg) * 33'(signed'({1'b0, dt_reg}));
                prod_reg <= 32'(w_reg) * 32'(signed'({1'b0, dt_reg}));
            end
            upi_pkg::ST_CORD0: begin
                if (cord_done) begin
                    c0_reg  <= cord_cos;
                    s0_reg  <= cord_sin;
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    if (w_reg == '0) begin
                        mcand_reg  <= ACC_W'(mag_p);
                        mplier_reg <= mag_cos;
                        neg_reg    <= p_reg[32] ^ cord_cos[upi_pkg::CS_W-1];
                    end else begin
                        mcand_reg  <= ACC_W'(mag_prod);
                        mplier_reg <= upi_pkg::HEAD_STEP_C;
                        neg_reg    <= prod_reg[31];
                    end
                end
            end
            upi_pkg::ST_CORD1: begin
                if (cord_done) begin
                    cnt_reg    <= '0;
                    acc_reg    <= '0;
                    mcand_reg  <= ACC_W'(mag_ds);
                    mplier_reg <= mag_v;
                    neg_reg    <= v_reg[upi_pkg::SPD_W-1] ^ diff_s[upi_pkg::CS_W] ^ w_reg[15];
                end
            end
            upi_pkg::ST_HMUL, upi_pkg::ST_SMULX, upi_pkg::ST_SMULY,
            upi_pkg::ST_AMULX, upi_pkg::ST_AMULY: begin
                if (cnt_reg != MUL_END) begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                end else begin
                    cnt_reg <= '0;
                    case (state_reg)
                        upi_pkg::ST_HMUL: th1_reg <= th1_comb;
                        upi_pkg::ST_SMULX: begin
                            dx_reg     <= straight_d;
                            acc_reg    <= '0;
                            mcand_reg  <= ACC_W'(mag_p);
                            mplier_reg <= mag_s0;
                            neg_reg    <= p_reg[32] ^ s0_reg[upi_pkg::CS_W-1];
                        end
                        upi_pkg::ST_SMULY: dy_reg <= straight_d;
                        default: begin
                            // arc: load divider with |num| + |den|/2
                            rem_reg <= '0;
                            dq_reg  <= div_init;
                            den_reg <= DEN_W'(mag_w) << 14;
                        end
                    endcase
                end
            end
            upi_pkg::ST_ADIVX, upi_pkg::ST_ADIVY: begin
                if (cnt_reg != DIV_END) begin
                    rem_reg <= qbit ? 31'(trial - 32'(den_reg)) : trial[30:0];
                    dq_reg  <= {dq_reg[DIV_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                end else if (state_reg == upi_pkg::ST_ADIVX) begin
                    dx_reg     <= div_d;
                    cnt_reg    <= '0;
                    acc_reg    <= '0;
                    mcand_reg  <= ACC_W'(mag_dc);
                    mplier_reg <= mag_v;
                    neg_reg    <= v_reg[upi_pkg::SPD_W-1] ^ diff_c[upi_pkg::CS_W] ^ w_reg[15];
                end else begin
                    dy_reg <= div_d;
                end
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // ---------------- pose update, saturating ----------------
    assign sum_x = {{(SUM_W-POSE_WIDTH){pos_x_reg[POSE_WIDTH-1]}}, pos_x_reg}
                 + {{(SUM_W-D_W){dx_reg[D_W-1]}}, dx_reg};
    assign sum_y = {{(SUM_W-POSE_WIDTH){pos_y_reg[POSE_WIDTH-1]}}, pos_y_reg}
                 + {{(SUM_W-D_W){dy_reg[D_W-1]}}, dy_reg};

    always_comb begin
        if (sum_x[SUM_W-1:POSE_WIDTH-1] == '0 || sum_x[SUM_W-1:POSE_WIDTH-1] == '1) begin
            sat_x = sum_x[POSE_WIDTH-1:0];
        end else begin
            sat_x = {sum_x[SUM_W-1], {(POSE_WIDTH-1){!sum_x[SUM_W-1]}}};
        end
        if (sum_y[SUM_W-1:POSE_WIDTH-1] == '0 || sum_y[SUM_W-1:POSE_WIDTH-1] == '1) begin
            sat_y = sum_y[POSE_WIDTH-1:0];
        end else begin
            sat_y = {sum_y[SUM_W-1], {(POSE_WIDTH-1){!sum_y[SUM_W-1]}}};
        end
    end

    assign ext_x       = {{(SUM_W-POSE_WIDTH){sat_x[POSE_WIDTH-1]}}, sat_x};
    assign ext_y       = {{(SUM_W-POSE_WIDTH){sat_y[POSE_WIDTH-1]}}, sat_y};
    assign heading_new = (w_reg == '0) ? heading_reg : th1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            heading_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == upi_pkg::ST_UPD && out_free) begin
            pos_x_reg    <= sat_x;
            pos_y_reg    <= sat_y;
            heading_reg  <= heading_new;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == upi_pkg::ST_UPD && out_free) begin
            m_tdata_reg <= {heading_new, ext_y[upi_pkg::OUT_W-1:0], ext_x[upi_pkg::OUT_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/upi_checker.sv =====
// ----------------------------------------------------------------------------
// upi_checker
// Port-level checks of the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
module upi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a held result beat stays
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // one sample at a time: busy right after an input beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // out of reset: idle and no result pending
    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> s_tready && !m_tvalid)
        else $error("bad state after reset");

    // a new result never appears in the beat right after an input beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
